// File: design/bcn_pkg.sv
// ---------------------------------------------------------------------------
// bcn_pkg: shared types and constants for the BC1..BC5 block decoder
// Request and response payloads, block format codes and stage records.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcn_pkg;

   typedef logic [2:0] fmt_type;

   localparam fmt_type FMT_BC1 = 3'd0;
   localparam fmt_type FMT_BC2 = 3'd1;
   localparam fmt_type FMT_BC3 = 3'd2;
   localparam fmt_type FMT_BC4 = 3'd3;
   localparam fmt_type FMT_BC5 = 3'd4;

   localparam logic [1:0] LAST_ROW = 2'd3;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [1:0]  row_index;
      logic [31:0] texel_col0;
      logic [31:0] texel_col1;
      logic [31:0] texel_col2;
      logic [31:0] texel_col3;
      logic        last_row;
   } rsp_type;

   // colour endpoints and the weighted sums behind the midpoints
   typedef struct packed {
      logic [2:0][7:0] p0;
      logic [2:0][7:0] p1;
      logic [2:0][9:0] s2;     // 2*p0 + p1
      logic [2:0][9:0] s3;     // p0 + 2*p1
      logic [2:0][8:0] sh;     // p0 + p1
      logic            three;  // 3-colour mode with transparent index 3
   } col_sums_type;

   // one interpolated 8-bit channel: endpoints and weighted sums
   typedef struct packed {
      logic [7:0]       a0;
      logic [7:0]       a1;
      logic             ramp7;
      logic [5:0][10:0] wsum;
   } chan_sums_type;

   typedef struct packed {
      fmt_type       fmt;
      col_sums_type  col;
      chan_sums_type cha;
      chan_sums_type chb;
      logic [31:0]   cidx;
      logic [63:0]   lo;
      logic [63:0]   hi;
   } s1_type;

   typedef struct packed {
      fmt_type          fmt;
      logic [3:0][31:0] pal;
      logic [7:0][7:0]  lva;
      logic [7:0][7:0]  lvb;
      logic [31:0]      cidx;
      logic [63:0]      lo;
      logic [63:0]      hi;
   } s2_type;

endpackage

`default_nettype wire

// File: design/bcn_texture_block_decoder.sv
// A request passes the endpoint, palette and block registers, then each row
// goes through the response register to the response port.
// Throughput: one response row per cycle while rsp_ready is high; the row
// emitter holds a block for its four rows and takes the next as the last leaves.
// Reset (synchronous, active high) empties the pipeline and sets fmt_ff to BC1.
// ---------------------------------------------------------------------------
// bcn_texture_block_decoder: BC1..BC5 4x4 texture block decoder
// Three register stages: endpoint expansion, palette build, row emission.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcn_texture_block_decoder (
   input  wire logic            clock,
   input  wire logic            reset,
   // format register
   input  wire logic            csr_we,
   input  wire bcn_pkg::fmt_type csr_wdata,
   // request channel: one compressed block
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire bcn_pkg::req_type req_data,
   // response channel: one texel row
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output bcn_pkg::rsp_type     rsp_data
);
   import bcn_pkg::*;

   // format register; it must be only written while the block is idle, which the
   // block does not enforce; each request takes its own copy into stage 1 anyway
   fmt_type fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_BC1;
      end else if (csr_we) begin
         fmt_ff <= csr_wdata;
      end
   end

   logic   s1_valid, s1_ready;
   s1_type s1_data;
   logic   s2_valid, s2_ready;
   s2_type s2_data;

   // stage 1: 565 expansion, BC1 mode select, weighted endpoint sums
   bcn_endpoint u_endpoint (
      .clock     (clock),
      .reset     (reset),
      .fmt       (fmt_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   // stage 2: divide by 3, 5, 7 via reciprocal multiplies -> palettes
   bcn_palette u_palette (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   // stage 3: per-row palette lookup into the response register; takes the
   // next block in the cycle its last row leaves
   bcn_row_emit u_row_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: design/bcn_endpoint.sv
// ---------------------------------------------------------------------------
// bcn_endpoint: first pipeline stage
// Expands 565 endpoints and forms the weighted sums for all palettes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcn_endpoint (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire bcn_pkg::fmt_type fmt,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire bcn_pkg::req_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output bcn_pkg::s1_type      out_data
);
   import bcn_pkg::*;

   logic   valid_ff, valid_in;
   s1_type data_ff, data_in;

   function automatic logic [2:0][7:0] expand565(input logic [15:0] c);
      logic [2:0][7:0] p;
      p[0] = {c[15:11], c[15:13]};
      p[1] = {c[10:5], c[10:9]};
      p[2] = {c[4:0], c[4:2]};
      return p;
   endfunction

   function automatic chan_sums_type chan_sums(input logic [63:0] w);
      chan_sums_type s;
      logic [10:0]   a0;
      logic [10:0]   a1;
      a0 = {3'b000, w[7:0]};
      a1 = {3'b000, w[15:8]};
      s.a0 = w[7:0];
      s.a1 = w[15:8];
      s.ramp7 = (w[7:0] > w[15:8]);
      for (int i = 1; i <= 6; i++) begin
         if (s.ramp7) begin
            s.wsum[i-1] = 11'(7 - i) * a0 + 11'(i) * a1;
         end else if (i <= 4) begin
            s.wsum[i-1] = 11'(5 - i) * a0 + 11'(i) * a1;
         end else begin
            s.wsum[i-1] = '0;
         end
      end
      return s;
   endfunction

   logic [63:0]  cword;
   col_sums_type col;

   always_comb begin
      cword = (fmt == FMT_BC1) ? in_data.block_low : in_data.block_high;
      col.p0 = expand565(cword[15:0]);
      col.p1 = expand565(cword[31:16]);
      for (int j = 0; j < 3; j++) begin
         col.s2[j] = {1'b0, col.p0[j], 1'b0} + {2'b00, col.p1[j]};
         col.s3[j] = {2'b00, col.p0[j]} + {1'b0, col.p1[j], 1'b0};
         col.sh[j] = {1'b0, col.p0[j]} + {1'b0, col.p1[j]};
      end
      col.three = (fmt == FMT_BC1) && (cword[15:0] <= cword[31:16]);
   end

   always_comb begin
      data_in.fmt  = fmt;
      data_in.col  = col;
      data_in.cha  = chan_sums(in_data.block_low);
      data_in.chb  = chan_sums(in_data.block_high);
      data_in.cidx = cword[63:32];
      data_in.lo   = in_data.block_low;
      data_in.hi   = in_data.block_high;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: design/bcn_palette.sv
// ---------------------------------------------------------------------------
// bcn_palette: second pipeline stage
// Turns weighted sums into palette colours and channel levels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcn_palette (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire bcn_pkg::s1_type in_data,
   output logic                out_valid,
   input  wire logic           out_ready,
   output bcn_pkg::s2_type     out_data
);
   import bcn_pkg::*;

   logic   valid_ff, valid_in;
   s2_type data_ff, data_in;

   // reciprocal multiplies, exact over the reachable sum ranges
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [19:0] p;
      p = {10'b0, x} * 20'd683;
      return p[18:11];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] p;
      p = {12'b0, x} * 23'd2341;
      return p[21:14];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [22:0] p;
      p = {12'b0, x} * 23'd3277;
      return p[21:14];
   endfunction

   function automatic logic [7:0][7:0] levels(input chan_sums_type s);
      logic [7:0][7:0] lv;
      lv[0] = s.a0;
      lv[1] = s.a1;
      for (int i = 0; i < 6; i++) begin
         lv[i+2] = div7(s.wsum[i]);
      end
      if (!s.ramp7) begin
         for (int i = 0; i < 4; i++) begin
            lv[i+2] = div5(s.wsum[i]);
         end
         lv[6] = 8'h00;
         lv[7] = 8'hFF;
      end
      return lv;
   endfunction

   always_comb begin
      data_in.fmt = in_data.fmt;
      data_in.pal[0] = {8'hFF, in_data.col.p0[2], in_data.col.p0[1], in_data.col.p0[0]};
      data_in.pal[1] = {8'hFF, in_data.col.p1[2], in_data.col.p1[1], in_data.col.p1[0]};
      if (in_data.col.three) begin
         data_in.pal[2] = {8'hFF, in_data.col.sh[2][8:1], in_data.col.sh[1][8:1],
                           in_data.col.sh[0][8:1]};
         data_in.pal[3] = '0;
      end else begin
         data_in.pal[2] = {8'hFF, div3(in_data.col.s2[2]), div3(in_data.col.s2[1]),
                           div3(in_data.col.s2[0])};
         data_in.pal[3] = {8'hFF, div3(in_data.col.s3[2]), div3(in_data.col.s3[1]),
                           div3(in_data.col.s3[0])};
      end
      data_in.lva  = levels(in_data.cha);
      data_in.lvb  = levels(in_data.chb);
      data_in.cidx = in_data.cidx;
      data_in.lo   = in_data.lo;
      data_in.hi   = in_data.hi;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: design/bcn_row_emit.sv
// ---------------------------------------------------------------------------
// bcn_row_emit: third stage and output register
// Holds one decoded block; sends one texel row per cycle unless stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcn_row_emit (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire bcn_pkg::s2_type in_data,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output bcn_pkg::rsp_type    rsp_data
);
   import bcn_pkg::*;

   logic       blk_valid_ff, blk_valid_in;
   s2_type     blk_ff;
   logic [1:0] row_ff, row_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load_out, done;

   logic [7:0]  crow;
   logic [15:0] arow;
   logic [11:0] sarow;
   logic [11:0] sbrow;
   logic [3:0][31:0] texels;

   function automatic logic [31:0] texel(input fmt_type fmt,
                                         input logic [31:0] colour,
                                         input logic [3:0] a4,
                                         input logic [7:0] la,
                                         input logic [7:0] lb);
      logic [31:0] t;
      case (fmt)
         FMT_BC1: t = colour;
         FMT_BC2: t = {a4, a4, colour[23:0]};
         FMT_BC3: t = {la, colour[23:0]};
         FMT_BC4: t = {8'hFF, 16'h0000, la};
         FMT_BC5: t = {8'hFF, 8'h00, lb, la};
         default: t = '0;
      endcase
      return t;
   endfunction

   always_comb begin
      crow  = blk_ff.cidx[8*row_ff +: 8];
      arow  = blk_ff.lo[16*row_ff +: 16];
      sarow = blk_ff.lo[16 + 12*row_ff +: 12];
      sbrow = blk_ff.hi[16 + 12*row_ff +: 12];
      for (int c = 0; c < 4; c++) begin
         texels[c] = texel(blk_ff.fmt, blk_ff.pal[crow[2*c +: 2]], arow[4*c +: 4],
                           blk_ff.lva[sarow[3*c +: 3]], blk_ff.lvb[sbrow[3*c +: 3]]);
      end
      rsp_in.row_index  = row_ff;
      rsp_in.texel_col0 = texels[0];
      rsp_in.texel_col1 = texels[1];
      rsp_in.texel_col2 = texels[2];
      rsp_in.texel_col3 = texels[3];
      rsp_in.last_row   = (row_ff == LAST_ROW);
   end

   assign load_out = blk_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign done     = load_out && (row_ff == LAST_ROW);
   assign in_ready = !blk_valid_ff || done;

   always_comb begin
      blk_valid_in = blk_valid_ff;
      if (in_valid && in_ready) begin
         blk_valid_in = 1'b1;
      end else if (done) begin
         blk_valid_in = 1'b0;
      end
      row_in = load_out ? row_ff + 2'd1 : row_ff;
      rsp_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff <= 1'b0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         blk_valid_ff <= blk_valid_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         blk_ff <= in_data;
      end
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: design/bcn_checker.sv
// ---------------------------------------------------------------------------
// bcn_checker: port-level checks for the block decoder
// Row order, last-row flag, stall hold, no orphan rows, empty after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcn_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire bcn_pkg::rsp_type rsp_data
);
   import bcn_pkg::*;

   logic [1:0] exp_row_ff, exp_row_in;
   logic [2:0] open_ff, open_in;
   logic       req_acc, rsp_acc, blk_done;

   assign req_acc  = req_valid && req_ready;
   assign rsp_acc  = rsp_valid && rsp_ready;
   assign blk_done = rsp_acc && rsp_data.last_row;

   assign exp_row_in = rsp_acc ? exp_row_ff + 2'd1 : exp_row_ff;
   assign open_in    = open_ff + {2'b00, req_acc} - {2'b00, blk_done};

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_row_ff <= '0;
         open_ff    <= '0;
      end else begin
         exp_row_ff <= exp_row_in;
         open_ff    <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.row_index == exp_row_ff)
      else $error("rows out of order");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last_row == (rsp_data.row_index == LAST_ROW))
      else $error("last_row flag mismatch");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 3'd0)
      else $error("response with no request outstanding");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind bcn_texture_block_decoder bcn_checker u_bcn_checker (.*);

`default_nettype wire

// File: verif/bcn_texture_block_decoder_tb.sv
// ---------------------------------------------------------------------------
// bcn_texture_block_decoder_tb: self-checking bench for the BC1..BC5 decoder
// Sends compressed 4x4 blocks under every block format and checks each texel
// row against a behavioral decoder or a known value, with random stalls on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcn_texture_block_decoder_tb;

   import bcn_pkg::*;

   // Codes 5..7 are not assigned; the decoder must return transparent black.
   localparam fmt_type FMT_RSVD_LO = 3'd5;
   localparam fmt_type FMT_RSVD_HI = 3'd7;

   localparam int MAX_WAIT     = 16;      // idle draw per request or row, both sides
   localparam int HOLD_CYCLES  = 120;     // one long response stall
   localparam int HOLD_AT_ROW  = 120;     // rows seen before that stall starts
   localparam int DRAIN_SLACK  = 8;       // settle time after the owed rows are back
   localparam int RAND_PHASES  = 10;
   localparam int PHASE_BLOCKS = 25;
   localparam int CYCLE_LIMIT  = 200000;

   // Directed probe: when 'known' is set, all 16 texels equal 'texel'
   // (values that fall straight out of the format rules); otherwise the
   // behavioral decoder supplies the rows.
   typedef struct packed {
      fmt_type     fmt;
      logic [63:0] lo;
      logic [63:0] hi;
      logic        known;
      logic [31:0] texel;
   } probe_type;

   typedef logic [15:0][31:0] block_texels_type;

   localparam int N_PROBES = 21;

   // Index pattern 0..7 packed as 3-bit fields, twice over the 48 index bits.
   localparam logic [47:0] ALL_LEVELS = 48'hFAC688_FAC688;

   localparam probe_type PROBES [N_PROBES] = '{
      // BC1 straight after reset, no register write yet.
      // All zero: equal endpoints put the block in 3-colour mode, index 0.
      '{FMT_BC1, 64'h0, 64'h0, 1'b1, 32'hFF000000},
      // All ones: equal endpoints, every index 3 -> transparent black.
      '{FMT_BC1, '1, '1, 1'b1, 32'h00000000},
      // 4-colour (red > blue), indices 0,1,2,3 in each row
      '{FMT_BC1, 64'hE4E4E4E4_001FF800, 64'h0, 1'b0, 32'h0},
      // 3-colour (blue < green), transparent index 3 present
      '{FMT_BC1, 64'hE4E4E4E4_07E0001F, 64'h0, 1'b0, 32'h0},
      // equal nonzero endpoints, indices 3,2,1,0
      '{FMT_BC1, 64'h1B1B1B1B_84108410, '1, 1'b0, 32'h0},
      // BC2: explicit alpha, colour always 4-colour
      '{FMT_BC2, 64'h0, 64'h0, 1'b1, 32'h00000000},
      '{FMT_BC2, '1, '1, 1'b1, 32'hFFFFFFFF},
      // c0 < c1 would be 3-colour in BC1; here index 3 must stay opaque
      '{FMT_BC2, 64'h01234567_89ABCDEF, 64'hE4E4E4E4_F800001F, 1'b0, 32'h0},
      // BC3: interpolated alpha
      '{FMT_BC3, 64'h0, 64'h0, 1'b1, 32'h00000000},
      '{FMT_BC3, '1, '1, 1'b1, 32'hFFFFFFFF},
      '{FMT_BC3, {ALL_LEVELS, 16'h10F0}, 64'hE4E4E4E4_0000FFFF, 1'b0, 32'h0},
      '{FMT_BC3, {ALL_LEVELS, 16'hF010}, 64'h1B1B1B1B_001FF800, 1'b0, 32'h0},
      // BC4: red only, high half ignored
      '{FMT_BC4, 64'h0, '1, 1'b1, 32'hFF000000},
      '{FMT_BC4, '1, 64'h0, 1'b1, 32'hFF0000FF},
      '{FMT_BC4, {ALL_LEVELS, 16'h20C0}, '1, 1'b0, 32'h0},
      '{FMT_BC4, {ALL_LEVELS, 16'hC020}, 64'h0, 1'b0, 32'h0},
      // BC5: red from the low half, green from the high half
      '{FMT_BC5, 64'h0, 64'h0, 1'b1, 32'hFF000000},
      '{FMT_BC5, '1, '1, 1'b1, 32'hFF00FFFF},
      '{FMT_BC5, {ALL_LEVELS, 16'h00FF}, {ALL_LEVELS, 16'hFF00}, 1'b0, 32'h0},
      // unassigned codes, lowest and highest: everything zero
      '{FMT_RSVD_LO, 64'h01234567_89ABCDEF, 64'hFEDCBA98_76543210, 1'b1, 32'h0},
      '{FMT_RSVD_HI, '1, '1, 1'b1, 32'h0}
   };

   // Rotation for the first random phases so every format gets a full set.
   localparam fmt_type FMT_ROTATION [5] = '{FMT_BC1, FMT_BC2, FMT_BC3, FMT_BC4, FMT_BC5};

   // -----------------------------------------------------------------------
   // DUT signals; every input known from time zero
   // -----------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    csr_we    = 1'b0;
   fmt_type csr_wdata = FMT_BC1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bcn_texture_block_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // -----------------------------------------------------------------------
   // Bench state
   // -----------------------------------------------------------------------
   rsp_type rows_due [$];        // texel rows still owed by the DUT, oldest first
   fmt_type active_fmt = FMT_BC1; // bench copy of the DUT format register (reset value)
   int      errors       = 0;
   int      blocks_sent  = 0;
   int      rows_checked = 0;
   int      fmt_writes   = 0;
   int      cycle_count  = 0;
   int      fmt_blocks [8];      // blocks decoded under each format code

   // -----------------------------------------------------------------------
   // Behavioral decoder
   // -----------------------------------------------------------------------

   // RGB565 -> 8 bits per channel by bit replication; [0]=R, [1]=G, [2]=B
   function automatic logic [2:0][7:0] widen565(logic [15:0] c);
      return {{c[4:0], c[4:2]}, {c[10:5], c[10:9]}, {c[15:11], c[15:13]}};
   endfunction

   // 8-byte colour half: two endpoints, 2-bit index per texel.
   // allow3 enables the 3-colour + transparent mode when c0 <= c1.
   function automatic block_texels_type colour_texels(logic [63:0] w, bit allow3);
      logic [2:0][7:0]  p0;
      logic [2:0][7:0]  p1;
      logic [3:0][31:0] pal;
      block_texels_type res;
      int               j;
      int               k;
      p0     = widen565(w[15:0]);
      p1     = widen565(w[31:16]);
      pal[0] = {8'hFF, p0[2], p0[1], p0[0]};
      pal[1] = {8'hFF, p1[2], p1[1], p1[0]};
      pal[2] = 32'hFF000000;
      if (!allow3 || (w[15:0] > w[31:16])) begin
         pal[3] = 32'hFF000000;
         for (j = 0; j < 3; j++) begin
            pal[2][8*j +: 8] = 8'((2 * int'(p0[j]) + int'(p1[j])) / 3);
            pal[3][8*j +: 8] = 8'((int'(p0[j]) + 2 * int'(p1[j])) / 3);
         end
      end else begin
         pal[3] = 32'h00000000;   // transparent black
         for (j = 0; j < 3; j++) begin
            pal[2][8*j +: 8] = 8'((int'(p0[j]) + int'(p1[j])) / 2);
         end
      end
      for (k = 0; k < 16; k++) begin
         res[k] = pal[w[32 + 2*k +: 2]];
      end
      return res;
   endfunction

   // 8-byte interpolated channel: 8-level ramp when a0 > a1, else 6-level
   // ramp plus 0 and 255. 3-bit selector per texel.
   function automatic logic [15:0][7:0] channel_bytes(logic [63:0] w);
      logic [7:0][7:0]  lv;
      logic [15:0][7:0] res;
      int               a0;
      int               a1;
      int               k;
      a0    = int'(w[7:0]);
      a1    = int'(w[15:8]);
      lv[0] = w[7:0];
      lv[1] = w[15:8];
      if (a0 > a1) begin
         for (k = 1; k <= 6; k++) begin
            lv[k+1] = 8'(((7 - k) * a0 + k * a1) / 7);
         end
      end else begin
         for (k = 1; k <= 4; k++) begin
            lv[k+1] = 8'(((5 - k) * a0 + k * a1) / 5);
         end
         lv[6] = 8'h00;
         lv[7] = 8'hFF;
      end
      for (k = 0; k < 16; k++) begin
         res[k] = lv[w[16 + 3*k +: 3]];
      end
      return res;
   endfunction

   function automatic block_texels_type decode_texels(fmt_type fmt, logic [63:0] lo,
                                                      logic [63:0] hi);
      block_texels_type tex;
      logic [15:0][7:0] red;
      logic [15:0][7:0] grn;
      int               k;
      tex = '0;
      case (fmt)
         FMT_BC1: begin
            tex = colour_texels(lo, 1'b1);
         end
         FMT_BC2: begin
            tex = colour_texels(hi, 1'b0);
            // 4-bit alpha scaled by 17 is the nibble repeated
            for (k = 0; k < 16; k++) begin
               tex[k][31:24] = {lo[4*k +: 4], lo[4*k +: 4]};
            end
         end
         FMT_BC3: begin
            tex = colour_texels(hi, 1'b0);
            red = channel_bytes(lo);
            for (k = 0; k < 16; k++) begin
               tex[k][31:24] = red[k];
            end
         end
         FMT_BC4, FMT_BC5: begin
            red = channel_bytes(lo);
            grn = (fmt == FMT_BC5) ? channel_bytes(hi) : '0;
            for (k = 0; k < 16; k++) begin
               tex[k] = {8'hFF, 8'h00, grn[k], red[k]};
            end
         end
         default: begin
            tex = '0;   // unassigned code: transparent black
         end
      endcase
      return tex;
   endfunction

   // -----------------------------------------------------------------------
   // Request side
   // -----------------------------------------------------------------------

   // Block until every owed row has come back, then give the pipeline time
   // to settle. Ends on a falling edge.
   task automatic wait_drained();
      while (rows_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   // Register write; only called with the pipeline empty.
   task automatic write_format(fmt_type fmt);
      csr_we     = 1'b1;
      csr_wdata  = fmt;
      @(negedge clock);
      csr_we     = 1'b0;
      active_fmt = fmt;
      fmt_writes++;
   endtask

   bit tx_burst = 1'b0;   // while set, requests go back to back

   // Offer one block; a format change first drains the DUT. The owed rows
   // are queued at the accepting edge, before row 0 can reach the response
   // side through the stage registers.
   task automatic send_block(fmt_type fmt, logic [63:0] lo, logic [63:0] hi,
                             logic known, logic [31:0] texel);
      int               gap;
      int               r;
      block_texels_type tex;
      rsp_type          row;
      if (fmt != active_fmt) begin
         @(negedge clock);
         req_valid = 1'b0;
         wait_drained();
         write_format(fmt);
      end
      if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clock);
      // valid only drops when there really is a gap
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = '{block_high: hi, block_low: lo};
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);

      tex = known ? {16{texel}} : decode_texels(fmt, lo, hi);
      for (r = 0; r < 4; r++) begin
         row.row_index  = 2'(r);
         row.texel_col0 = tex[4*r];
         row.texel_col1 = tex[4*r + 1];
         row.texel_col2 = tex[4*r + 2];
         row.texel_col3 = tex[4*r + 3];
         row.last_row   = (2'(r) == LAST_ROW);
         rows_due.push_back(row);
      end
      blocks_sent++;
      fmt_blocks[fmt]++;
   endtask

   // Random block half. Some draws force equal endpoints (3-colour mode
   // in BC1, 6-level ramp for channels) or the all-zero / all-one extremes.
   function automatic logic [63:0] random_half();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0:       w[31:16] = w[15:0];
         1:       w[15:8]  = w[7:0];
         2:       w = '0;
         3:       w = '1;
         default: ;
      endcase
      return w;
   endfunction

   // -----------------------------------------------------------------------
   // Response side
   // -----------------------------------------------------------------------

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   bit rx_burst  = 1'b0;
   bit held_once = 1'b0;
   int longest_hold = 0;

   // Draws a stall before every row; once, a long hold-off lets the
   // pipeline fill so req_ready has to drop.
   initial begin : response_side
      int      stall;
      rsp_type want;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
         if (!held_once && rows_checked >= HOLD_AT_ROW) begin
            stall     = HOLD_CYCLES;
            held_once = 1'b1;
         end
         if (stall > longest_hold) longest_hold = stall;
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);

         if (rows_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected row, expected none, actual %h", $time, rsp_data);
         end else begin
            want = rows_due.pop_front();
            check_field("row_index",  32'(want.row_index),  32'(rsp_data.row_index));
            check_field("texel_col0", want.texel_col0,       rsp_data.texel_col0);
            check_field("texel_col1", want.texel_col1,       rsp_data.texel_col1);
            check_field("texel_col2", want.texel_col2,       rsp_data.texel_col2);
            check_field("texel_col3", want.texel_col3,       rsp_data.texel_col3);
            check_field("last_row",   32'(want.last_row),   32'(rsp_data.last_row));
         end
         rows_checked++;
         @(negedge clock);
      end
   end

   // Watchdog: a hung handshake or a lost row ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d rows still owed", $time, rows_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin : stimulus
      int      p;
      int      n;
      int      rsvd_blocks;
      fmt_type fmt;
      foreach (fmt_blocks[p]) fmt_blocks[p] = 0;

      // synchronous reset, released on a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed probes: reset format first, then each format in turn,
      // including the lowest and highest unassigned codes.
      for (p = 0; p < N_PROBES; p++) begin
         send_block(PROBES[p].fmt, PROBES[p].lo, PROBES[p].hi,
                    PROBES[p].known, PROBES[p].texel);
      end

      // Random phases: one per format, then random settings with an
      // occasional unassigned code.
      for (p = 0; p < RAND_PHASES; p++) begin
         if (p < 5)
            fmt = FMT_ROTATION[p];
         else if ($urandom_range(0, 7) == 0)
            fmt = fmt_type'($urandom_range(FMT_RSVD_LO, FMT_RSVD_HI));
         else
            fmt = fmt_type'($urandom_range(FMT_BC1, FMT_BC5));
         for (n = 0; n < PHASE_BLOCKS; n++) begin
            send_block(fmt, random_half(), random_half(), 1'b0, 32'h0);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      wait_drained();

      rsvd_blocks = 0;
      for (p = FMT_RSVD_LO; p <= FMT_RSVD_HI; p++) begin
         rsvd_blocks += fmt_blocks[p];
      end

      $display("Decoded %0d blocks (%0d rows), %0d format writes, longest hold-off %0d",
               blocks_sent, rows_checked, fmt_writes, longest_hold);
      $display("Blocks per format BC1..BC5: %0d %0d %0d %0d %0d, unassigned %0d; %0d errors",
               fmt_blocks[FMT_BC1], fmt_blocks[FMT_BC2], fmt_blocks[FMT_BC3],
               fmt_blocks[FMT_BC4], fmt_blocks[FMT_BC5], rsvd_blocks, errors);
      if (errors == 0 && rows_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
